@@ hw/rtl/sws_pkg.sv @@
// Shared types and constants for the sliding-window mean / std block.
// No dependencies; used by every module under hw/rtl.
package sws_pkg;

  localparam int LEN_W = 11;                          // window_length register width
  localparam logic [LEN_W-1:0] LEN_RESET = 11'd64;    // window_length after reset
  localparam int VW = 64;                             // width of m*Q, S*S and the variance
  localparam int FRAC_W = 8;                          // fractional bits of both results
  localparam int ROOT_W = VW / 2 + FRAC_W;            // root bits: one per bit pair of v*2^16
  localparam int START_W = 32;
  localparam int MEAN_W = 24;
  localparam int STD_W = 24;
  localparam int OUT_W = START_W + MEAN_W + STD_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PREP,
    ST_MUL,
    ST_VAR,
    ST_ROOT,
    ST_OUT
  } sws_state_t;

  // Control of one serial unit: load its operands, or advance one step.
  typedef struct packed {
    logic load;
    logic step;
  } sws_ctl_t;

endpackage

@@ hw/rtl/sws_ser_mul.sv @@
// Shift-and-add multiplier, one multiplier bit per step, product kept mod 2^P_W.
// Depends on sws_pkg (control struct).
module sws_ser_mul #(
  parameter int A_W = 16,
  parameter int B_W = 16,
  parameter int P_W = 32
) (
  input  logic               clk,
  input  sws_pkg::sws_ctl_t  ctl,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [P_W-1:0]     prod
);

  logic [P_W-1:0] mcand;
  logic [B_W-1:0] mplier;
  logic [P_W-1:0] acc;

  // once the multiplier bits run out, further steps leave acc unchanged
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mcand  <= P_W'(a);
      mplier <= b;
      acc    <= '0;
    end else if (ctl.step) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

  assign prod = acc;

endmodule

@@ hw/rtl/sws_div.sv @@
// Restoring divider fed with the dividend one bit per step, MSB first.
// Keeps the low Q_W quotient bits and flags a nonzero remainder. Depends on sws_pkg.
module sws_div #(
  parameter int D_W = 11,
  parameter int Q_W = 24
) (
  input  logic               clk,
  input  sws_pkg::sws_ctl_t  ctl,
  input  logic               bit_in,
  input  logic [D_W-1:0]     divisor,
  output logic [Q_W-1:0]     quot,
  output logic               rem_nz
);

  logic [D_W-1:0] rem;
  logic [D_W:0]   trial;
  logic           ge;

  assign trial = {rem, bit_in};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem  <= '0;
      quot <= '0;
    end else if (ctl.step) begin
      rem  <= ge ? D_W'(trial - {1'b0, divisor}) : trial[D_W-1:0];
      quot <= {quot[Q_W-2:0], ge};
    end
  end

  assign rem_nz = rem != '0;

endmodule

@@ hw/rtl/sws_sqrt.sv @@
// Digit-by-digit integer square root of v*2^16, one root bit per step, MSB first.
// The newest root bit is exposed for a divider running one step behind. Depends on sws_pkg.
module sws_sqrt (
  input  logic                    clk,
  input  sws_pkg::sws_ctl_t       ctl,
  input  logic [sws_pkg::VW-1:0]  value,
  output logic                    root_bit
);

  localparam int RW = sws_pkg::ROOT_W;

  logic [sws_pkg::VW-1:0] vsh;
  logic [RW-1:0]          root;
  logic [RW+1:0]          rem;
  logic [RW+3:0]          rem_sh;
  logic [RW+3:0]          trial;
  logic                   ge;

  // vsh shifts in zeros, which supplies the trailing zero pairs for the scaling
  assign rem_sh = {rem, vsh[sws_pkg::VW-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      vsh  <= value;
      root <= '0;
      rem  <= '0;
    end else if (ctl.step) begin
      vsh  <= vsh << 2;
      rem  <= ge ? (RW+2)'(rem_sh - trial) : rem_sh[RW+1:0];
      root <= {root[RW-2:0], ge};
    end
  end

  assign root_bit = root[0];

endmodule

@@ hw/rtl/sliding_window_mean_std_top.sv @@
// Sliding-window mean and population std, top level: sample ring, running sums,
// sequencer and output register. Depends on sws_pkg, sws_ser_mul, sws_div, sws_sqrt.
//
// Usage:
//   s_axis carries one signed sample per item in s_axis_tdata; m_axis carries one
//   result per sample once window_length samples have arrived since reset or the
//   last write to the length register: window start index, mean and std (Q.8).
//   cfg_wr_en/cfg_wr_data write window_length (0 acts as 1, large values saturate)
//   and restart the window; write it only while no item is in flight.
// Sequencing:
//   Items are handled one at a time. A sample that yields no result frees the input
//   once the square sum is updated; one that yields a result goes on to the output
//   register and m_axis_tvalid. The product phase runs on the shift-add multipliers;
//   the root phase yields one bit of the 40-bit root per cycle, with the std divider
//   one step behind and the mean divider running alongside.
// Reset:
//   rst clears the sums, counters and fill; window_length returns to 64. The ring
//   needs no clearing: an entry's value is only used after it has been written.
// Stall:
//   A result waits in the output register; the next sample is accepted meanwhile and
//   its result is held in the sequencer until m_axis_tready frees the register.
module sliding_window_mean_std_top #(
  parameter int WINDOW_MAX  = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [sws_pkg::LEN_W-1:0]           cfg_wr_data,   // window_length
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,  // sample
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [sws_pkg::OUT_W-1:0]           m_axis_tdata   // window_start, mean_q8, std_q8
);

  localparam int LEN_W   = sws_pkg::LEN_W;
  localparam int SLOT_W  = $clog2(WINDOW_MAX);
  localparam int CW      = (SLOT_W + 1 > LEN_W) ? SLOT_W + 1 : LEN_W;
  localparam int M_CAP   = (WINDOW_MAX > 2**LEN_W - 1) ? 2**LEN_W - 1 : WINDOW_MAX;
  localparam int M_RST   = (M_CAP < int'(sws_pkg::LEN_RESET)) ? M_CAP
                                                              : int'(sws_pkg::LEN_RESET);
  localparam int DM_W    = SAMPLE_BITS + 1;
  localparam int SUM_W   = SAMPLE_BITS + LEN_W;
  localparam int SQ_W    = 2 * SAMPLE_BITS + LEN_W;
  localparam int MEAN_N  = SUM_W + sws_pkg::FRAC_W;
  localparam int MQ_LOAD = DM_W + 1;
  localparam int MUL_N   = (SUM_W > MQ_LOAD + 1 + LEN_W) ? SUM_W : MQ_LOAD + 1 + LEN_W;
  localparam int ROOT_N  = (sws_pkg::ROOT_W + 1 > MEAN_N) ? sws_pkg::ROOT_W + 1 : MEAN_N;
  localparam int CNT_W   = $clog2(((MUL_N > ROOT_N) ? MUL_N : ROOT_N) + 1);

  sws_pkg::sws_state_t state, state_next;
  logic [CNT_W-1:0]    cnt, cnt_next;

  logic [LEN_W-1:0]    mlen;
  logic [CW-1:0]       fill;
  logic [CW-1:0]       fill_inc;
  logic [SLOT_W-1:0]   write_slot;
  logic [SLOT_W-1:0]   old_slot;
  logic [31:0]         seen;
  logic signed [SUM_W-1:0] sum;
  logic [SQ_W-1:0]     sq;

  logic signed [SAMPLE_BITS-1:0] ring [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic signed [SAMPLE_BITS-1:0] old_val;
  logic                full_r;
  logic                emit_r;
  logic signed [DM_W-1:0] dif_c, sm_c;
  logic signed [DM_W-1:0] dif_r, sm_r;
  logic                d_neg;
  logic [31:0]         ws_r;
  logic [SUM_W-1:0]    s_abs;
  logic [MEAN_N-1:0]   mean_sh;
  logic                mean_neg;

  logic                acc_in;
  logic                out_load;
  sws_pkg::sws_ctl_t   dmul_ctl, ssmul_ctl, mqmul_ctl, sqrt_ctl, mdiv_ctl, sdiv_ctl;

  logic [2*DM_W-1:0]          d_prod;
  logic [sws_pkg::VW-1:0]     ss_prod, mq_prod, var_v;
  logic                       root_bit;
  logic [sws_pkg::MEAN_W-1:0] mean_q, mean_val;
  logic                       mean_rnz;
  logic [sws_pkg::STD_W-1:0]  std_q;
  logic                       std_rnz;
  logic [LEN_W-1:0]           cfg_len;
  logic [CW-1:0]              ws_ext, m_ext, slot_diff;

  assign acc_in = s_axis_tvalid && s_axis_tready;

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sws_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    dmul_ctl      = '0;
    ssmul_ctl     = '0;
    mqmul_ctl     = '0;
    sqrt_ctl      = '0;
    mdiv_ctl      = '0;
    sdiv_ctl      = '0;
    case (state)
      sws_pkg::ST_IDLE: begin
        s_axis_tready = !rst;
        if (s_axis_tvalid) begin
          state_next = sws_pkg::ST_LOAD;
        end
      end
      sws_pkg::ST_LOAD: begin
        state_next = sws_pkg::ST_PREP;
      end
      sws_pkg::ST_PREP: begin
        dmul_ctl.load  = 1'b1;
        ssmul_ctl.load = 1'b1;
        cnt_next       = '0;
        state_next     = sws_pkg::ST_MUL;
      end
      sws_pkg::ST_MUL: begin
        dmul_ctl.step  = 1'b1;
        ssmul_ctl.step = 1'b1;
        mqmul_ctl.load = cnt == CNT_W'(MQ_LOAD);
        mqmul_ctl.step = cnt > CNT_W'(MQ_LOAD);
        cnt_next       = cnt + 1'b1;
        // the square sum is updated by now; without a result the item is done
        if (cnt == CNT_W'(MQ_LOAD) && !emit_r) begin
          state_next = sws_pkg::ST_IDLE;
        end else if (cnt == CNT_W'(MUL_N - 1)) begin
          state_next = sws_pkg::ST_VAR;
        end
      end
      sws_pkg::ST_VAR: begin
        sqrt_ctl.load = 1'b1;
        mdiv_ctl.load = 1'b1;
        sdiv_ctl.load = 1'b1;
        cnt_next      = '0;
        state_next    = sws_pkg::ST_ROOT;
      end
      sws_pkg::ST_ROOT: begin
        sqrt_ctl.step = cnt < CNT_W'(sws_pkg::ROOT_W);
        sdiv_ctl.step = cnt != '0 && cnt <= CNT_W'(sws_pkg::ROOT_W);
        mdiv_ctl.step = cnt < CNT_W'(MEAN_N);
        cnt_next      = cnt + 1'b1;
        if (cnt == CNT_W'(ROOT_N - 1)) begin
          state_next = sws_pkg::ST_OUT;
        end
      end
      sws_pkg::ST_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = sws_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sws_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------- window bookkeeping ----------------
  assign cfg_len = (cfg_wr_data == '0) ? LEN_W'(1)
                 : (cfg_wr_data > LEN_W'(M_CAP)) ? LEN_W'(M_CAP) : cfg_wr_data;

  assign fill_inc  = (fill == CW'(WINDOW_MAX)) ? fill : fill + 1'b1;
  assign ws_ext    = CW'(write_slot);
  assign m_ext     = CW'(mlen);
  assign slot_diff = (ws_ext >= m_ext) ? ws_ext - m_ext : ws_ext + CW'(WINDOW_MAX) - m_ext;
  assign old_slot  = slot_diff[SLOT_W-1:0];

  assign old_val = full_r ? rd_data : '0;
  assign dif_c   = DM_W'(x_r) - DM_W'(old_val);
  assign sm_c    = DM_W'(x_r) + DM_W'(old_val);
  assign s_abs   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      mlen <= LEN_W'(M_RST);
      fill <= '0;
      sum  <= '0;
      sq   <= '0;
    end else if (cfg_wr_en) begin
      mlen <= cfg_len;
      fill <= '0;
      sum  <= '0;
      sq   <= '0;
    end else begin
      if (state == sws_pkg::ST_LOAD) begin
        fill <= fill_inc;
        sum  <= sum + SUM_W'(dif_c);
      end
      // x^2 - old^2 = (x - old)(x + old), done in sign-magnitude
      if (state == sws_pkg::ST_MUL && cnt == CNT_W'(DM_W)) begin
        sq <= d_neg ? sq - SQ_W'(d_prod) : sq + SQ_W'(d_prod);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      seen       <= '0;
    end else if (state == sws_pkg::ST_LOAD) begin
      write_slot <= (write_slot == SLOT_W'(WINDOW_MAX - 1)) ? '0 : write_slot + 1'b1;
      seen       <= seen + 32'd1;
    end
  end

  // sample ring: oldest sample read at acceptance, new sample written in the cycle after, in the load step
  always_ff @(posedge clk) begin
    if (acc_in) begin
      rd_data <= ring[old_slot];
    end
    if (state == sws_pkg::ST_LOAD) begin
      ring[write_slot] <= x_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      x_r    <= s_axis_tdata[SAMPLE_BITS-1:0];
      full_r <= fill >= m_ext;
    end
    if (state == sws_pkg::ST_LOAD) begin
      dif_r  <= dif_c;
      sm_r   <= sm_c;
      emit_r <= fill_inc >= m_ext;
      ws_r   <= seen + 32'd1 - 32'(mlen);
    end
    if (state == sws_pkg::ST_PREP) begin
      d_neg <= dif_r[DM_W-1] ^ sm_r[DM_W-1];
    end
    if (state == sws_pkg::ST_VAR) begin
      mean_neg <= sum[SUM_W-1];
      mean_sh  <= {s_abs, sws_pkg::FRAC_W'(0)};
    end else if (mdiv_ctl.step) begin
      mean_sh <= mean_sh << 1;
    end
  end

  // ---------------- serial units ----------------
  sws_ser_mul #(.A_W(DM_W), .B_W(DM_W), .P_W(2 * DM_W)) u_dmul (
    .clk  (clk),
    .ctl  (dmul_ctl),
    .a    (dif_r[DM_W-1] ? DM_W'(-dif_r) : DM_W'(dif_r)),
    .b    (sm_r[DM_W-1] ? DM_W'(-sm_r) : DM_W'(sm_r)),
    .prod (d_prod)
  );

  sws_ser_mul #(.A_W(SUM_W), .B_W(SUM_W), .P_W(sws_pkg::VW)) u_ssmul (
    .clk  (clk),
    .ctl  (ssmul_ctl),
    .a    (s_abs),
    .b    (s_abs),
    .prod (ss_prod)
  );

  sws_ser_mul #(.A_W(SQ_W), .B_W(LEN_W), .P_W(sws_pkg::VW)) u_mqmul (
    .clk  (clk),
    .ctl  (mqmul_ctl),
    .a    (sq),
    .b    (mlen),
    .prod (mq_prod)
  );

  assign var_v = (mq_prod > ss_prod) ? mq_prod - ss_prod : '0;

  sws_sqrt u_sqrt (
    .clk      (clk),
    .ctl      (sqrt_ctl),
    .value    (var_v),
    .root_bit (root_bit)
  );

  sws_div #(.D_W(LEN_W), .Q_W(sws_pkg::STD_W)) u_sdiv (
    .clk     (clk),
    .ctl     (sdiv_ctl),
    .bit_in  (root_bit),
    .divisor (mlen),
    .quot    (std_q),
    .rem_nz  (std_rnz)
  );

  sws_div #(.D_W(LEN_W), .Q_W(sws_pkg::MEAN_W)) u_mdiv (
    .clk     (clk),
    .ctl     (mdiv_ctl),
    .bit_in  (mean_sh[MEAN_N-1]),
    .divisor (mlen),
    .quot    (mean_q),
    .rem_nz  (mean_rnz)
  );

  // floor of a negative quotient: -(q + (rem != 0))
  assign mean_val = !mean_neg ? mean_q
                  : mean_rnz ? ~mean_q : ~mean_q + sws_pkg::MEAN_W'(1);

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {std_q, mean_val, ws_r};
    end
  end

  // ---------------- assertions ----------------
  a_accept_to_load: assert property (@(posedge clk) disable iff (rst)
    acc_in |=> state == sws_pkg::ST_LOAD)
    else $error("accepted item did not enter the load step");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(WINDOW_MAX))
    else $error("fill count beyond ring depth");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    mlen != '0 && mlen <= LEN_W'(M_CAP))
    else $error("effective window length out of range");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> fill == '0 && sum == '0 && sq == '0)
    else $error("length write did not restart the window");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    state == sws_pkg::ST_OUT && m_axis_tvalid && !m_axis_tready
      |=> state == sws_pkg::ST_OUT && $stable(m_axis_tdata))
    else $error("pending result overwritten while stalled");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for sliding_window_mean_std_top: drives samples and length
// writes, predicts window start, mean and std for each full window, checks every result item.
// Depends on sws_pkg and the RTL under hw/rtl.
`timescale 1ns / 1ps

module testbench;

  // packed from the top down: std in the high bits, window start in the low bits
  typedef struct packed {
    logic [sws_pkg::STD_W-1:0]   sdev_q8;
    logic [sws_pkg::MEAN_W-1:0]  mean_q8;
    logic [sws_pkg::START_W-1:0] start_idx;
  } window_stats_t;

  typedef enum int {MIX_FULL, MIX_RAILS, MIX_SMALL, MIX_FLAT} mix_t;

  localparam int RING_DEPTH = 1024;

  // Predicts the stats of each window and queues them until the block delivers them.
  class window_stats_board;
    logic signed [15:0]        history [RING_DEPTH];
    int unsigned               slot;
    int unsigned               filled;
    int unsigned               seen;
    longint                    total;
    longint unsigned           square_total;
    logic [sws_pkg::LEN_W-1:0] length_reg;
    window_stats_t             pending[$];
    int                        errors;

    function new();
      length_reg = sws_pkg::LEN_RESET;
      slot = 0;
      seen = 0;
      errors = 0;
      set_length(sws_pkg::LEN_RESET);
    endfunction

    // Length write: restarts the window, slot and index counters keep running.
    function void set_length(logic [sws_pkg::LEN_W-1:0] len);
      length_reg = len;
      total = 0;
      square_total = 0;
      filled = 0;
    endfunction

    function int unsigned span();
      if (length_reg == 0) return 1;
      if (length_reg > RING_DEPTH) return RING_DEPTH;
      return length_reg;
    endfunction

    function void note_sample(logic signed [15:0] x);
      int unsigned     m;
      longint          xs;
      longint          old;
      longint          scaled;
      longint          q;
      longint unsigned mag;
      longint unsigned prod;
      longint unsigned var_term;
      logic [127:0]    target;
      logic [127:0]    root;
      logic [127:0]    cand;
      window_stats_t   r;
      m = span();
      xs = x;
      if (filled >= m) begin
        old = history[(slot + RING_DEPTH - m) % RING_DEPTH];
        total -= old;
        square_total -= old * old;
      end
      history[slot] = x;
      total += xs;
      square_total += xs * xs;
      slot = (slot + 1) % RING_DEPTH;
      seen++;
      if (filled < RING_DEPTH) filled++;
      if (filled < m) return;

      // floored mean: C-style division truncates, so fix up negatives
      scaled = total * 256;
      q = scaled / longint'(m);
      if (scaled % longint'(m) != 0 && scaled < 0) q--;

      mag = (total < 0) ? -total : total;
      prod = longint'(m) * square_total;
      var_term = (prod > mag * mag) ? prod - mag * mag : 64'd0;

      // floor(sqrt(var * 2^16)), one root bit at a time from the top
      target = {64'd0, var_term} << 16;
      root = '0;
      for (int b = 39; b >= 0; b--) begin
        cand = root | (128'd1 << b);
        if (cand * cand <= target) root = cand;
      end
      root = root / m;

      r.start_idx = seen - m;
      r.mean_q8 = q[sws_pkg::MEAN_W-1:0];
      r.sdev_q8 = root[sws_pkg::STD_W-1:0];
      pending.push_back(r);
    endfunction

    task report(string what);
      errors++;
      $display("mismatch at %0t: %s", $time, what);
    endtask

    task check_result(window_stats_t got);
      window_stats_t want;
      if (pending.size() == 0) begin
        report($sformatf("result %h with no window pending", got));
        return;
      end
      want = pending.pop_front();
      if (got.start_idx !== want.start_idx)
        report($sformatf("window_start %0d, expected %0d", got.start_idx, want.start_idx));
      if (got.mean_q8 !== want.mean_q8)
        report($sformatf("mean_q8 %h, expected %h (start %0d)",
                         got.mean_q8, want.mean_q8, want.start_idx));
      if (got.sdev_q8 !== want.sdev_q8)
        report($sformatf("std_q8 %h, expected %h (start %0d)",
                         got.sdev_q8, want.sdev_q8, want.start_idx));
    endtask
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_wr_en = 1'b0;
  logic [sws_pkg::LEN_W-1:0] cfg_wr_data = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [15:0]               s_axis_tdata = '0;   // sample
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [sws_pkg::OUT_W-1:0] m_axis_tdata;        // window_start, mean_q8, std_q8

  window_stats_board  board;
  bit                 send_gaps = 1'b1;
  bit                 recv_gaps = 1'b1;
  bit                 hold_request = 1'b0;
  logic [15:0]        flat_level = '0;

  logic [15:0] rail_vals [12] = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000,
                                  16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA, 16'h7FFF,
                                  16'h8000, 16'h00FF};
  logic [15:0] unit_vals [6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001,
                                 16'h0100};
  logic [15:0] pair_vals [6] = '{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
                                 16'h7FFF};

  sliding_window_mean_std_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [15:0] pick_sample(mix_t mix);
    if ($urandom_range(0, 9) == 0) return 16'($urandom_range(0, 65535));
    case (mix)
      MIX_RAILS: begin
        if ($urandom_range(0, 2) == 0) return 16'h8000;
        if ($urandom_range(0, 1) == 0) return 16'h7FFF;
        return 16'($urandom_range(0, 65535));
      end
      MIX_SMALL: return 16'(int'($urandom_range(0, 16)) - 8);
      MIX_FLAT:  return flat_level;
      default:   return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task send_sample(logic [15:0] x);
    int gap;
    gap = send_gaps ? $urandom_range(0, 17) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata <= x;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    board.note_sample(x);
    @(negedge clk);
  endtask

  // Sender pauses until every window result is out and the block has gone quiet.
  task drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task configure(logic [sws_pkg::LEN_W-1:0] len);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    board.set_length(len);
  endtask

  task run_phase(logic [sws_pkg::LEN_W-1:0] len, int count, mix_t mix, bit squeeze);
    configure(len);
    send_gaps = ($urandom_range(0, 3) != 0);
    recv_gaps = ($urandom_range(0, 3) != 0);
    flat_level = 16'($urandom_range(0, 65535));
    // long receiver stall while samples keep coming: output and input back up
    if (squeeze) hold_request = 1'b1;
    repeat (count) send_sample(pick_sample(mix));
  endtask

  // Result receiver
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = recv_gaps ? $urandom_range(0, 17) : 0;
      if (hold_request) begin
        hold_request = 1'b0;
        stall = 300;
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      board.check_result(m_axis_tdata);
      @(negedge clk);
    end
  end

  initial begin
    board = new();
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset length of 64: rails first, window fills with random samples
    foreach (rail_vals[i]) send_sample(rail_vals[i]);
    repeat (56) send_sample(pick_sample(MIX_FULL));

    // length zero acts as one
    configure(11'd0);
    foreach (unit_vals[i]) send_sample(unit_vals[i]);

    // two-sample windows at the rails: extreme means and spread
    configure(11'd2);
    foreach (pair_vals[i]) send_sample(pair_vals[i]);

    // all ones saturates to the ring depth
    run_phase(11'd2047, RING_DEPTH + 40, MIX_RAILS, 1'b0);

    // window never fills before the next write restarts it
    run_phase(11'd20, 12, MIX_SMALL, 1'b0);

    run_phase(11'd3, 50, MIX_RAILS, 1'b1);

    for (int k = 0; k < 10; k++)
      run_phase((k < 3) ? sws_pkg::LEN_W'(k + 1)
                        : sws_pkg::LEN_W'($urandom_range(1, 48)), 30,
                mix_t'($urandom_range(0, 3)), 1'b0);

    drain();
    repeat (60) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/sws_pkg.sv
hw/rtl/sws_ser_mul.sv
hw/rtl/sws_div.sv
hw/rtl/sws_sqrt.sv
hw/rtl/sliding_window_mean_std_top.sv
verif/testbench.sv
